[rtl/scd_pkg.sv]
// scd_pkg: shared constants, types and the quarter-wave sine table of the stereo chorus delay.
// Used by every module of the block. Depends on nothing.
package scd_pkg;

	localparam int LINE_DEPTH  = 4096;
	localparam int ADDR_W      = $clog2(LINE_DEPTH);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int SAMPLE_W    = 16;
	localparam int SINE_POINTS = 1024;
	localparam int SINE_AW     = $clog2(SINE_POINTS);
	localparam int QTR_AW      = SINE_AW - 2;
	localparam int QTR_PTS     = SINE_POINTS / 4;
	localparam int PHASE_W     = 32;
	localparam int DLY_W       = 20;
	localparam int FRAC_W      = 8;
	localparam int MIX_W       = 16;
	localparam int WID_W       = 15;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(4);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(LINE_DEPTH);
	localparam logic [MIX_W-1:0] MIX_FULL  = MIX_W'(32768);
	localparam logic [WID_W-1:0] WIDTH_MAX = WID_W'(24576);

	localparam logic [PHASE_W-1:0] RST_PHASE_STEP = 32'd53687;
	localparam logic [DLY_W-1:0]   RST_CENTER     = 20'd147456;
	localparam logic [DLY_W-1:0]   RST_SWEEP      = 20'd33178;
	localparam logic [MIX_W-1:0]   RST_MIX        = 16'd13107;
	localparam logic [WID_W-1:0]   RST_WIDTH      = 15'd19661;
	localparam logic [LEN_W-1:0]   RST_LEN        = 13'd2404;
	localparam logic [PHASE_W-1:0] RST_R_PHASE    = 32'h4000_0000;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP = 3'd0,
		CFG_CENTER     = 3'd1,
		CFG_SWEEP      = 3'd2,
		CFG_MIX        = 3'd3,
		CFG_WIDTH      = 3'd4,
		CFG_LENGTH     = 3'd5,
		CFG_STEREO     = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LN_IDLE, LN_MUL, LN_SUB, LN_DIV
	} lane_front_t;

	typedef enum logic [3:0] {
		LS_IDLE, LS_MUL, LS_SUB, LS_DST, LS_DIV, LS_RDA, LS_RDB, LS_INT
	} lane_state_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_LANE, ST_MIX, ST_OUT
	} top_state_t;

	typedef struct packed {
		logic                en;
		logic [ADDR_W-1:0]   addr;
		logic [SAMPLE_W-1:0] data;
	} line_wr_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [DLY_W-1:0] center;
		logic [DLY_W-1:0] sweep;
	} lane_cfg_t;

	typedef logic [15:0] qtr_rom_t [0:QTR_PTS];

	// sin over the first quarter, Q30 taylor series to x^11, rounded to Q15
	function automatic logic [15:0] sine_qtr(int j);
		logic [63:0] u;
		logic [63:0] x;
		logic [63:0] term;
		longint      s;
		longint      r;
		u    = 64'(j) << (30 - QTR_AW);
		x    = (u * HALF_PI_Q30) >> 30;
		term = x;
		s    = longint'(x);
		term = ((((term * x) >> 30) * x) >> 30) / 6;
		s    = s - longint'(term);
		term = ((((term * x) >> 30) * x) >> 30) / 20;
		s    = s + longint'(term);
		term = ((((term * x) >> 30) * x) >> 30) / 42;
		s    = s - longint'(term);
		term = ((((term * x) >> 30) * x) >> 30) / 72;
		s    = s + longint'(term);
		term = ((((term * x) >> 30) * x) >> 30) / 110;
		s    = s - longint'(term);
		if (s < 0) s = 0;
		r = (s + 16384) >>> 15;
		if (r > 32767) r = 32767;
		return r[15:0];
	endfunction

	function automatic qtr_rom_t build_qtr();
		qtr_rom_t t;
		for (int j = 0; j <= QTR_PTS; j++) t[j] = sine_qtr(j);
		return t;
	endfunction

	localparam qtr_rom_t SINE_QTR = build_qtr();

	function automatic sample_t sat_sample(logic signed [23:0] v);
		if (v > 24'sd32767) return sample_t'(16'sh7FFF);
		if (v < -24'sd32768) return sample_t'(16'sh8000);
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

[rtl/scd_rem.sv]
// scd_rem: restoring remainder unit, one quotient bit per cycle.
// Depends on scd_pkg for the line length width.
module scd_rem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [scd_pkg::LEN_W-1:0] dividend,
	input  logic [scd_pkg::LEN_W-1:0] divisor,
	output logic                      done,
	output logic [scd_pkg::LEN_W-1:0] rem
);
	import scd_pkg::*;

	localparam int CNT_W = $clog2(LEN_W + 1);

	logic [LEN_W-1:0] quo_q;
	logic [LEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W:0]   trial;

	assign trial = {rem_q, quo_q[LEN_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(LEN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_q << 1;
			if (trial >= {1'b0, divisor}) rem_q <= LEN_W'(trial - {1'b0, divisor});
			else rem_q <= trial[LEN_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

[rtl/scd_lane.sv]
// scd_lane: one channel's modulated tap: sine lookup, delay, read position, line memory,
// linear interpolation. Depends on scd_pkg and scd_rem.
module scd_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [scd_pkg::PHASE_W-1:0] phase,
	input  logic [scd_pkg::ADDR_W-1:0]  wr_idx,
	input  scd_pkg::lane_cfg_t          cfg,
	input  scd_pkg::line_wr_t           line_wr,
	output logic                        done,
	output scd_pkg::sample_t            wet
);
	import scd_pkg::*;

	localparam int POS_W = ADDR_W + FRAC_W;

	lane_state_t state_q, state_d;

	logic [SAMPLE_W-1:0] mem [0:LINE_DEPTH-1];
	logic [SAMPLE_W-1:0] rd_data_q;
	logic [ADDR_W-1:0]   rd_addr;
	logic                rd_en;

	logic [SINE_AW-1:0]     rom_addr;
	logic [1:0]             quad;
	logic [QTR_AW:0]        rom_j;
	logic signed [15:0]     sine_r;
	logic signed [15:0]     sine_s;
	logic [15:0]            mod_m;
	logic [DLY_W+15:0]      prod_q;
	logic [DLY_W:0]         delay;
	logic [DLY_W:0]         wi_pos;
	logic [DLY_W:0]         abs_q;
	logic                   neg_q;
	logic                   rem_start;
	logic                   rem_done;
	logic [LEN_W-1:0]       rem_val;
	logic [DLY_W:0]         rv;
	logic [DLY_W:0]         total;
	logic [DLY_W:0]         pos;
	logic [ADDR_W-1:0]      i0;
	logic [LEN_W-1:0]       i0_inc;
	logic [ADDR_W-1:0]      i0_q;
	logic [ADDR_W-1:0]      i1_q;
	logic [FRAC_W-1:0]      frac_q;
	sample_t                a_q;
	logic signed [16:0]     diff;
	logic signed [25:0]     acc;
	sample_t                wet_q;
	logic                   done_q;

	// quarter-wave lookup with symmetry
	always_comb begin
		rom_addr = phase[PHASE_W-1 -: SINE_AW];
		quad     = rom_addr[SINE_AW-1 -: 2];
		if (quad[0]) rom_j = (QTR_AW+1)'(QTR_PTS) - {1'b0, rom_addr[QTR_AW-1:0]};
		else rom_j = {1'b0, rom_addr[QTR_AW-1:0]};
		sine_r = $signed(SINE_QTR[rom_j]);
		sine_s = quad[1] ? -sine_r : sine_r;
		mod_m  = {~sine_s[15], sine_s[14:0]};
	end

	always_comb begin
		delay  = {1'b0, cfg.center} + {1'b0, prod_q[DLY_W+15:16]};
		wi_pos = (DLY_W+1)'({wr_idx, {FRAC_W{1'b0}}});
		total  = (DLY_W+1)'({cfg.len, {FRAC_W{1'b0}}});
		rv     = (DLY_W+1)'({rem_val, abs_q[FRAC_W-1:0]});
		if (!neg_q) pos = rv;
		else if (rv == '0) pos = '0;
		else pos = total - rv;
		i0     = pos[POS_W-1:FRAC_W];
		i0_inc = {1'b0, i0} + 1'b1;
	end

	scd_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (abs_q[DLY_W:FRAC_W]),
		.divisor  (cfg.len),
		.done     (rem_done),
		.rem      (rem_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == LS_INT);
		end
	end

	always_comb begin
		state_d   = state_q;
		rem_start = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = i0_q;
		case (state_q)
			LS_IDLE: if (start) state_d = LS_MUL;
			LS_MUL:  state_d = LS_SUB;
			LS_SUB:  state_d = LS_DST;
			LS_DST: begin
				rem_start = 1'b1;
				state_d   = LS_DIV;
			end
			LS_DIV:  if (rem_done) state_d = LS_RDA;
			LS_RDA: begin
				rd_en   = 1'b1;
				state_d = LS_RDB;
			end
			LS_RDB: begin
				rd_en   = 1'b1;
				rd_addr = i1_q;
				state_d = LS_INT;
			end
			LS_INT:  state_d = LS_IDLE;
			default: state_d = LS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == LS_MUL) prod_q <= cfg.sweep * mod_m;
		if (state_q == LS_SUB) begin
			neg_q <= delay > wi_pos;
			abs_q <= (delay > wi_pos) ? delay - wi_pos : wi_pos - delay;
		end
		if (state_q == LS_DIV && rem_done) begin
			i0_q   <= i0;
			i1_q   <= (i0_inc >= cfg.len) ? '0 : i0_inc[ADDR_W-1:0];
			frac_q <= pos[FRAC_W-1:0];
		end
		if (state_q == LS_RDB) a_q <= rd_data_q;
		if (state_q == LS_INT) wet_q <= acc[23:8];
	end

	// a*256 + (b - a)*frac + 128, floor by 256
	always_comb begin
		diff = 17'($signed(rd_data_q)) - 17'(a_q);
		acc  = 26'({a_q, {FRAC_W{1'b0}}}) + 26'(diff) * 26'($signed({1'b0, frac_q}))
			+ 26'sd128;
	end

	always_ff @(posedge clk) begin
		if (line_wr.en) mem[line_wr.addr] <= line_wr.data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign done = done_q;
	assign wet  = wet_q;

endmodule

[rtl/scd_mix.sv]
// scd_mix: merging stage: mid/side widening of the two wet taps, then dry/wet mix
// with saturation. Four pipeline stages. Depends on scd_pkg.
module scd_mix (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  scd_pkg::sample_t          wet_l,
	input  scd_pkg::sample_t          wet_r,
	input  scd_pkg::sample_t          dry_l,
	input  scd_pkg::sample_t          dry_r,
	input  logic [scd_pkg::WID_W-1:0] width,
	input  logic [scd_pkg::MIX_W-1:0] mix,
	input  logic                      stereo,
	output logic                      done,
	output scd_pkg::sample_t          out_l,
	output scd_pkg::sample_t          out_r
);
	import scd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [16:0] mid_s1;
	logic signed [32:0] side_s1;
	logic signed [33:0] dryp_l_s1, dryp_r_s1;
	logic signed [19:0] wet_l_s2, wet_r_s2;
	logic signed [33:0] dryp_l_s2, dryp_r_s2;
	logic signed [37:0] wetp_l_s3, wetp_r_s3;
	logic signed [33:0] dryp_l_s3, dryp_r_s3;
	sample_t            out_l_s4, out_r_s4;

	logic [MIX_W:0]     dmix;
	logic signed [34:0] mid_w;
	logic signed [34:0] sum_l, sum_r;
	logic signed [38:0] tot_l, tot_r;

	always_comb begin
		dmix  = 17'd32768 - {1'b0, mix};
		mid_w = 35'(mid_s1) <<< 14;
		sum_l = mid_w + 35'(side_s1) + 35'sd16384;
		sum_r = mid_w - 35'(side_s1) + 35'sd16384;
		tot_l = 39'(wetp_l_s3) + 39'(dryp_l_s3) + 39'sd16384;
		tot_r = 39'(wetp_r_s3) + 39'(dryp_r_s3) + 39'sd16384;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mid_s1    <= 17'(wet_l) + 17'(wet_r);
			side_s1   <= (17'(wet_l) - 17'(wet_r)) * $signed({1'b0, width});
			dryp_l_s1 <= dry_l * $signed({1'b0, dmix});
			dryp_r_s1 <= dry_r * $signed({1'b0, dmix});
		end
		if (v_s1) begin
			wet_l_s2  <= sum_l[34:15];
			wet_r_s2  <= sum_r[34:15];
			dryp_l_s2 <= dryp_l_s1;
			dryp_r_s2 <= dryp_r_s1;
		end
		if (v_s2) begin
			wetp_l_s3 <= wet_l_s2 * $signed({1'b0, mix, 1'b0}) >>> 1;
			wetp_r_s3 <= wet_r_s2 * $signed({1'b0, mix, 1'b0}) >>> 1;
			dryp_l_s3 <= dryp_l_s2;
			dryp_r_s3 <= dryp_r_s2;
		end
		if (v_s3) begin
			out_l_s4 <= sat_sample(tot_l[38:15]);
			out_r_s4 <= stereo ? sat_sample(tot_r[38:15]) : sample_t'(0);
		end
	end

	assign done  = v_s4;
	assign out_l = out_l_s4;
	assign out_r = out_r_s4;

endmodule

[rtl/stereo_chorus_delay_unit.sv]
// Stereo chorus delay, top level: configuration registers, write index, LFO phases,
// sequencing of the two tap lanes and the merging stage. Depends on scd_pkg, scd_lane, scd_mix.
//
// One stereo pair (Q1.15) goes in, one mixed pair comes out. After reset both delay
// lines are swept to zero, one entry per cycle, so the input stays not ready until
// every entry has been swept; configuration writes are taken at any time. A pair
// passes through both tap lanes, then the merging stage, into the output register, and
// the next pair is accepted in the cycle after the result lands there, even while it
// still waits for its output transfer. Most of that time is spent in the 13-step remainder
// unit in each lane that wraps the read position onto the active line length; the two
// lanes run side by side, each with its own line memory read twice per pair.
module stereo_chorus_delay_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  scd_pkg::sample_t               left_in,
	input  scd_pkg::sample_t               right_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output scd_pkg::sample_t               left_out,
	output scd_pkg::sample_t               right_out,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import scd_pkg::*;

	top_state_t state_q, state_d;

	logic [PHASE_W-1:0] phase_step_q;
	logic [DLY_W-1:0]   center_q;
	logic [DLY_W-1:0]   sweep_q;
	logic [MIX_W-1:0]   mix_q;
	logic [WID_W-1:0]   width_q;
	logic [LEN_W-1:0]   length_q;
	logic               stereo_q;

	logic [ADDR_W-1:0]  clr_q;
	logic [ADDR_W-1:0]  wr_idx_q;
	logic [PHASE_W-1:0] l_phase_q;
	logic [PHASE_W-1:0] r_phase_q;
	sample_t            dry_l_q, dry_r_q;
	logic               out_valid_q;
	sample_t            left_out_q, right_out_q;

	logic [LEN_W-1:0]   len_eff;
	logic [MIX_W-1:0]   mix_eff;
	logic [WID_W-1:0]   width_eff;
	logic [LEN_W-1:0]   wi_inc;
	lane_cfg_t          lane_cfg;
	line_wr_t           wr_l, wr_r;
	logic               in_xfer;
	logic               lane_start;
	logic               done_l, done_r;
	sample_t            wet_l, wet_r;
	logic               mix_done;
	sample_t            mix_l, mix_r;
	logic               load_out;
	logic               step_done;

	always_comb begin
		if (length_q < LEN_MIN) len_eff = LEN_MIN;
		else if (length_q > LEN_MAX) len_eff = LEN_MAX;
		else len_eff = length_q;
		mix_eff   = (mix_q > MIX_FULL) ? MIX_FULL : mix_q;
		width_eff = (width_q > WIDTH_MAX) ? WIDTH_MAX : width_q;
		wi_inc    = {1'b0, wr_idx_q} + 1'b1;
		lane_cfg  = '{len: len_eff, center: center_q, sweep: sweep_q};
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= RST_PHASE_STEP;
			center_q     <= RST_CENTER;
			sweep_q      <= RST_SWEEP;
			mix_q        <= RST_MIX;
			width_q      <= RST_WIDTH;
			length_q     <= RST_LEN;
			stereo_q     <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PHASE_STEP: phase_step_q <= cfg_data;
				CFG_CENTER:     center_q     <= cfg_data[DLY_W-1:0];
				CFG_SWEEP:      sweep_q      <= cfg_data[DLY_W-1:0];
				CFG_MIX:        mix_q        <= cfg_data[MIX_W-1:0];
				CFG_WIDTH:      width_q      <= cfg_data[WID_W-1:0];
				CFG_LENGTH:     length_q     <= cfg_data[LEN_W-1:0];
				CFG_STEREO:     stereo_q     <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		lane_start = 1'b0;
		step_done  = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					lane_start = 1'b1;
					state_d    = ST_LANE;
				end
			end
			ST_LANE: begin
				if (done_l && done_r) begin
					step_done = 1'b1;
					state_d   = ST_MIX;
				end
			end
			ST_MIX: if (mix_done) state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_xfer = lane_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			wr_idx_q    <= '0;
			l_phase_q   <= '0;
			r_phase_q   <= RST_R_PHASE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (step_done) begin
				l_phase_q <= l_phase_q + phase_step_q;
				r_phase_q <= r_phase_q + phase_step_q;
				wr_idx_q  <= (wi_inc >= len_eff) ? '0 : wi_inc[ADDR_W-1:0];
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dry_l_q <= left_in;
			dry_r_q <= stereo_q ? right_in : left_in;
		end
		if (load_out) begin
			left_out_q  <= mix_l;
			right_out_q <= mix_r;
		end
	end

	// sweep the lines after reset, otherwise write the pair once both taps are read
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_l = '{en: 1'b1, addr: clr_q, data: '0};
			wr_r = '{en: 1'b1, addr: clr_q, data: '0};
		end else begin
			wr_l = '{en: step_done, addr: wr_idx_q, data: dry_l_q};
			wr_r = '{en: step_done, addr: wr_idx_q, data: dry_r_q};
		end
	end

	scd_lane u_lane_l (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (lane_start),
		.phase   (l_phase_q),
		.wr_idx  (wr_idx_q),
		.cfg     (lane_cfg),
		.line_wr (wr_l),
		.done    (done_l),
		.wet     (wet_l)
	);

	scd_lane u_lane_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (lane_start),
		.phase   (r_phase_q),
		.wr_idx  (wr_idx_q),
		.cfg     (lane_cfg),
		.line_wr (wr_r),
		.done    (done_r),
		.wet     (wet_r)
	);

	scd_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_done),
		.wet_l  (wet_l),
		.wet_r  (wet_r),
		.dry_l  (dry_l_q),
		.dry_r  (dry_r_q),
		.width  (width_eff),
		.mix    (mix_eff),
		.stereo (stereo_q),
		.done   (mix_done),
		.out_l  (mix_l),
		.out_r  (mix_r)
	);

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

endmodule

[rtl/scd_check.sv]
// scd_check: port-level checks of the stereo chorus delay, bound to the top level.
// Depends on scd_pkg.
module scd_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  scd_pkg::sample_t               left_in,
	input  scd_pkg::sample_t               right_in,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  scd_pkg::sample_t               left_out,
	input  scd_pkg::sample_t               right_out,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import scd_pkg::*;

	// one pair at a time: busy right after an input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an input transfer");

	// a new result only appears while no input could be taken
	a_rise_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the input side was idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before its transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(left_out) && $stable(right_out))
		else $error("stalled result changed");

endmodule

bind stereo_chorus_delay_unit scd_check u_scd_check (.*);

[tb/stereo_chorus_delay_unit_test.sv]
// Self-checking testbench for stereo_chorus_delay_unit: runs directed and random stereo
// pairs through several register settings and checks each output pair against a built-in
// predictor or a fixed expected pair. Depends on scd_pkg and the stereo_chorus_delay_unit RTL.
`timescale 1ns / 1ps

module stereo_chorus_delay_unit_test;
	import scd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS   = 95;

	typedef struct {
		sample_t l;
		sample_t r;
	} pair_t;

	typedef struct {
		logic [31:0] step;
		logic [31:0] center;
		logic [31:0] sweep;
		logic [31:0] mix;
		logic [31:0] width;
		logic [31:0] len;
		logic [31:0] stereo;
	} chorus_cfg_t;

	typedef struct {
		sample_t l;
		sample_t r;
		bit      typed;
		sample_t exp_l;
		sample_t exp_r;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	sample_t left_in;
	sample_t right_in;
	logic out_valid;
	logic out_ready;
	sample_t left_out;
	sample_t right_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stereo_chorus_delay_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .left_in(left_in), .right_in(right_in),
		.out_valid(out_valid), .out_ready(out_ready), .left_out(left_out), .right_out(right_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	int      sine_tab [SINE_POINTS];
	sample_t left_hist [LINE_DEPTH];
	sample_t right_hist [LINE_DEPTH];
	longint  wr_pos;
	logic [31:0] lfo_left;
	logic [31:0] lfo_right;
	longint  p_step, p_center, p_sweep, p_mix, p_width, p_len, p_stereo;

	pair_t   expected_pairs [$];
	int      mismatches;
	bit      quiet;

	function automatic int sine_entry(int k);
		logic [63:0] t;
		logic [63:0] u;
		logic [63:0] x;
		logic [63:0] term;
		longint      s;
		longint      r;
		t = 64'(k) << 22;
		u = t & 64'h3FFF_FFFF;
		if (t[30]) u = 64'h4000_0000 - u;
		x = (u * HALF_PI_Q30) >> 30;
		term = x;
		s = longint'(x);
		for (int n = 1; n <= 5; n++) begin
			term = ((((term * x) >> 30) * x) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
			if (n % 2 == 1) s = s - longint'(term);
			else s = s + longint'(term);
		end
		if (s < 0) s = 0;
		r = (s + 16384) >>> 15;
		if (r > 32767) r = 32767;
		return t[31] ? -int'(r) : int'(r);
	endfunction

	// fractional tap behind the write position, linear interpolation
	function automatic longint tap_read(bit right_side, logic [31:0] phase, longint len);
		longint total;
		longint m;
		longint dly;
		longint pos;
		longint i0;
		longint i1;
		longint frac;
		longint a;
		longint b;
		total = len * 256;
		m = sine_tab[phase[31:22]] + 32768;
		dly = p_center + ((p_sweep * m) >> 16);
		pos = (wr_pos * 256 + total - dly % total) % total;
		i0 = pos >> 8;
		i1 = i0 + 1;
		frac = pos & 255;
		if (i1 >= len) i1 = 0;
		a = right_side ? right_hist[i0] : left_hist[i0];
		b = right_side ? right_hist[i1] : left_hist[i1];
		return (a * 256 + (b - a) * frac + 128) >>> 8;
	endfunction

	function automatic sample_t clip16(longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return sample_t'(v[15:0]);
	endfunction

	function automatic pair_t chorus_predict(sample_t l, sample_t r);
		longint len;
		longint mix;
		longint width;
		longint in_l;
		longint in_r;
		longint wl;
		longint wr;
		longint mid;
		longint side;
		pair_t  res;
		len = p_len < 4 ? 4 : (p_len > LINE_DEPTH ? LINE_DEPTH : p_len);
		mix = p_mix > 32768 ? 32768 : p_mix;
		width = p_width > 24576 ? 24576 : p_width;
		in_l = l;
		in_r = p_stereo != 0 ? longint'(r) : in_l;
		wl = tap_read(1'b0, lfo_left, len);
		wr = tap_read(1'b1, lfo_right, len);
		mid = (wl + wr) * 16384;
		side = (wl - wr) * width;
		wl = (mid + side + 16384) >>> 15;
		wr = (mid - side + 16384) >>> 15;
		left_hist[wr_pos] = sample_t'(in_l);
		right_hist[wr_pos] = sample_t'(in_r);
		res.l = clip16((in_l * (32768 - mix) + wl * mix + 16384) >>> 15);
		res.r = p_stereo != 0 ? clip16((in_r * (32768 - mix) + wr * mix + 16384) >>> 15) : '0;
		lfo_left = lfo_left + p_step[31:0];
		lfo_right = lfo_right + p_step[31:0];
		wr_pos = (wr_pos + 1 >= len) ? 0 : wr_pos + 1;
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 2_000_000);
		$display("stereo_chorus_delay_unit_test: done, errors");
		$finish;
	end

	always @(negedge clk) out_ready <= quiet || ($urandom_range(99) >= 23);

	// compare each output transfer with the oldest expected pair
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pairs.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected output %0d %0d at %0t", left_out, right_out, $realtime);
				mismatches++;
			end else begin
				if (left_out !== expected_pairs[0].l) begin
					if (mismatches < 10)
						$display("left_out exp %0d got %0d at %0t",
							expected_pairs[0].l, left_out, $realtime);
					mismatches++;
				end
				if (right_out !== expected_pairs[0].r) begin
					if (mismatches < 10)
						$display("right_out exp %0d got %0d at %0t",
							expected_pairs[0].r, right_out, $realtime);
					mismatches++;
				end
				void'(expected_pairs.pop_front());
			end
		end
	end

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_PHASE_STEP: p_step = data;
			CFG_CENTER:     p_center = data[19:0];
			CFG_SWEEP:      p_sweep = data[19:0];
			CFG_MIX:        p_mix = data[15:0];
			CFG_WIDTH:      p_width = data[14:0];
			CFG_LENGTH:     p_len = data[12:0];
			CFG_STEREO:     p_stereo = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_cfg(chorus_cfg_t c);
		reg_write(CFG_PHASE_STEP, c.step);
		reg_write(CFG_CENTER, c.center);
		reg_write(CFG_SWEEP, c.sweep);
		reg_write(CFG_MIX, c.mix);
		reg_write(CFG_WIDTH, c.width);
		reg_write(CFG_LENGTH, c.len);
		reg_write(CFG_STEREO, c.stereo);
		reg_write(CFG_UNUSED, $urandom);
	endtask

	// one input transfer; valid stays up across back-to-back pairs
	task automatic send_pair(sample_t l, sample_t r, bit typed, sample_t el, sample_t er);
		pair_t res;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		res = chorus_predict(l, r);
		if (typed) begin
			res.l = el;
			res.r = er;
		end
		expected_pairs.push_back(res);
	endtask

	function automatic sample_t rand_sample();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) return sample_t'($urandom);
		if (sel < 85) begin
			case ($urandom_range(3))
				0: return 16'sh7FFF;
				1: return 16'sh8000;
				2: return 16'sh0000;
				default: return 16'shFFFF;
			endcase
		end
		return sample_t'($urandom_range(510) - 255);
	endfunction

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	dir_row_t    dir_rows [12];
	chorus_cfg_t fixed_cfgs [7];
	chorus_cfg_t c;

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		left_in = '0;
		right_in = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		quiet = 1'b0;

		for (int k = 0; k < SINE_POINTS; k++) sine_tab[k] = sine_entry(k);
		for (int k = 0; k < LINE_DEPTH; k++) begin
			left_hist[k] = '0;
			right_hist[k] = '0;
		end
		wr_pos = 0;
		lfo_left = 32'h0;
		lfo_right = RST_R_PHASE;
		p_step = RST_PHASE_STEP;
		p_center = RST_CENTER;
		p_sweep = RST_SWEEP;
		p_mix = RST_MIX;
		p_width = RST_WIDTH;
		p_len = RST_LEN;
		p_stereo = 1;

		// silence into empty lines gives silence; the rest go through the predictor
		dir_rows = '{
			'{16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
			'{16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
			'{16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh0, 16'sh0},
			'{16'sh8000, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
			'{16'sh7FFF, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
			'{16'sh8000, 16'sh7FFF, 1'b0, 16'sh0, 16'sh0},
			'{16'sh0001, 16'shFFFF, 1'b0, 16'sh0, 16'sh0},
			'{16'shFFFF, 16'sh0001, 1'b0, 16'sh0, 16'sh0},
			'{16'sh5555, 16'shAAAA, 1'b0, 16'sh0, 16'sh0},
			'{16'shAAAA, 16'sh5555, 1'b0, 16'sh0, 16'sh0},
			'{16'sh4000, 16'shC000, 1'b0, 16'sh0, 16'sh0},
			'{16'sh1234, 16'shEDCB, 1'b0, 16'sh0, 16'sh0}
		};

		// extremes, out-of-range lengths and levels, mono, shortened lines
		fixed_cfgs = '{
			'{32'hFFFF_FFFF, 32'd0, 32'd0, 32'd32768, 32'd24576, 32'd4, 32'd1},
			'{32'h00A0_0000, 32'hFFFFF, 32'hFFFFF, 32'hFFFF, 32'h7FFF, 32'd4096, 32'd1},
			'{32'd0, 32'd300, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
			'{32'd12345678, 32'd5000, 32'd20000, 32'd16384, 32'd8192, 32'h1FFF, 32'd1},
			'{32'd53687, 32'd147456, 32'd33178, 32'd13107, 32'd19661, 32'd37, 32'd1},
			'{32'h4000_0000, 32'd2000, 32'd900, 32'd32767, 32'd24577, 32'd3, 32'd0},
			'{32'h0123_4567, 32'd1200, 32'd5000, 32'd32769, 32'd100, 32'd4097, 32'd1}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_pair(dir_rows[i].l, dir_rows[i].r, dir_rows[i].typed,
				dir_rows[i].exp_l, dir_rows[i].exp_r);
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_pair(rand_sample(), rand_sample(), 1'b0, '0, '0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			if (ph < 7) begin
				c = fixed_cfgs[ph];
			end else begin
				c.step = $urandom_range(3) == 0 ? $urandom : $urandom_range(400000);
				c.center = $urandom_range(3) == 0 ? $urandom : $urandom_range(40000);
				c.sweep = $urandom_range(3) == 0 ? $urandom : $urandom_range(40000);
				c.mix = $urandom_range(3) == 0 ? $urandom : $urandom_range(32768);
				c.width = $urandom_range(3) == 0 ? $urandom : $urandom_range(24576);
				c.len = $urandom_range(3) == 0 ? $urandom : $urandom_range(200, 4);
				c.stereo = $urandom;
			end
			apply_cfg(c);
			quiet = (ph == 2);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_pair(rand_sample(), rand_sample(), 1'b0, '0, '0);
			drain();
		end

		if (mismatches == 0)
			$display("stereo_chorus_delay_unit_test: done, clean");
		else
			$display("stereo_chorus_delay_unit_test: done, errors");
		$finish;
	end

endmodule
